// ===== src/cbad_pkg.sv =====
// ----------------------------------------------------------------------------
// cbad_pkg
// Shared types, address map constants and the boot program image for the
// console bus address decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbad_pkg;

    // store geometry
    localparam int WRAM_DEPTH = 8192;
    localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
    localparam int HRAM_DEPTH = 127;
    localparam int HRAM_AW    = $clog2(HRAM_DEPTH);
    localparam int BOOT_DEPTH = 256;
    localparam int BOOT_AW    = $clog2(BOOT_DEPTH);

    // dma run length in steps
    localparam logic [7:0] DMA_LENGTH = 8'd160;

    // address map
    localparam logic [15:0] ADDR_BOOT_END  = 16'h0100;
    localparam logic [15:0] ADDR_ROM_LAST  = 16'h7FFF;
    localparam logic [15:0] ADDR_VRAM_LAST = 16'h9FFF;
    localparam logic [15:0] ADDR_XRAM_LAST = 16'hBFFF;
    localparam logic [15:0] ADDR_WRAM_LAST = 16'hDFFF;
    localparam logic [15:0] ADDR_ECHO_LAST = 16'hFDFF;
    localparam logic [15:0] ADDR_OAM_FIRST = 16'hFE00;
    localparam logic [15:0] ADDR_OAM_LAST  = 16'hFE9F;
    localparam logic [15:0] ADDR_IO_FIRST  = 16'hFF00;
    localparam logic [15:0] ADDR_IO_LAST   = 16'hFF7F;
    localparam logic [15:0] ADDR_JOYPAD    = 16'hFF00;
    localparam logic [15:0] ADDR_TIMER_LO  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMER_HI  = 16'hFF07;
    localparam logic [15:0] ADDR_IF        = 16'hFF0F;
    localparam logic [15:0] ADDR_VID_LO    = 16'hFF40;
    localparam logic [15:0] ADDR_VID_HI    = 16'hFF4B;
    localparam logic [15:0] ADDR_LINE      = 16'hFF44;
    localparam logic [15:0] ADDR_DMA       = 16'hFF46;
    localparam logic [15:0] ADDR_BOOT_OFF  = 16'hFF50;
    localparam logic [15:0] ADDR_HRAM_LO   = 16'hFF80;
    localparam logic [15:0] ADDR_HRAM_HI   = 16'hFFFE;
    localparam logic [15:0] ADDR_IE        = 16'hFFFF;

    localparam logic [7:0] UNMAPPED_BYTE = 8'hFF;

    // bus commands
    typedef enum logic [2:0] {
        CMD_READ  = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_TICK  = 3'd2,
        CMD_HALT  = 3'd3,
        CMD_ACK   = 3'd4
    } cmd_t;

    // access targets
    typedef enum logic [2:0] {
        T_LOCAL   = 3'd0,
        T_IGNORED = 3'd1,
        T_CART    = 3'd2,
        T_VRAM    = 3'd3,
        T_OAM     = 3'd4,
        T_JOYPAD  = 3'd5,
        T_TIMER   = 3'd6,
        T_VIDREG  = 3'd7
    } target_t;

    // request into the ram store
    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic               hram_sel;
        logic [WRAM_AW-1:0] waddr;
        logic [HRAM_AW-1:0] haddr;
        logic [7:0]         wdata;
    } mem_req_t;

    // one result word
    typedef struct packed {
        logic [7:0]  rdata;
        target_t     target;
        logic        fwd_write;
        logic [15:0] fwd_addr;
        logic [7:0]  fwd_data;
        logic        oam_by_dma;
        logic        cpu_step;
        logic        dma_step;
        logic        periph_tick;
        logic        halted_now;
        logic        int_check_now;
    } result_t;

    // boot program image
    localparam logic [7:0] BOOT_ROM [BOOT_DEPTH] = '{
        8'h31, 8'hFE, 8'hFF, 8'hAF, 8'h21, 8'hFF, 8'h9F, 8'h32,
        8'hCB, 8'h7C, 8'h20, 8'hFB, 8'h21, 8'h26, 8'hFF, 8'h0E,
        8'h11, 8'h3E, 8'h80, 8'h32, 8'hE2, 8'h0C, 8'h3E, 8'hF3,
        8'hE2, 8'h32, 8'h3E, 8'h77, 8'h77, 8'h3E, 8'hFC, 8'hE0,
        8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1A,
        8'hCD, 8'h95, 8'h00, 8'hCD, 8'h96, 8'h00, 8'h13, 8'h7B,
        8'hFE, 8'h34, 8'h20, 8'hF3, 8'h11, 8'hD8, 8'h00, 8'h06,
        8'h08, 8'h1A, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hF9,
        8'h3E, 8'h19, 8'hEA, 8'h10, 8'h99, 8'h21, 8'h2F, 8'h99,
        8'h0E, 8'h0C, 8'h3D, 8'h28, 8'h08, 8'h32, 8'h0D, 8'h20,
        8'hF9, 8'h2E, 8'h0F, 8'h18, 8'hF3, 8'h67, 8'h3E, 8'h64,
        8'h57, 8'hE0, 8'h42, 8'h3E, 8'h91, 8'hE0, 8'h40, 8'h04,
        8'h1E, 8'h02, 8'h0E, 8'h0C, 8'hF0, 8'h44, 8'hFE, 8'h90,
        8'h20, 8'hFA, 8'h0D, 8'h20, 8'hF7, 8'h1D, 8'h20, 8'hF2,
        8'h0E, 8'h13, 8'h24, 8'h7C, 8'h1E, 8'h83, 8'hFE, 8'h62,
        8'h28, 8'h06, 8'h1E, 8'hC1, 8'hFE, 8'h64, 8'h20, 8'h06,
        8'h7B, 8'hE2, 8'h0C, 8'h3E, 8'h87, 8'hE2, 8'hF0, 8'h42,
        8'h90, 8'hE0, 8'h42, 8'h15, 8'h20, 8'hD2, 8'h05, 8'h20,
        8'h4F, 8'h16, 8'h20, 8'h18, 8'hCB, 8'h4F, 8'h06, 8'h04,
        8'hC5, 8'hCB, 8'h11, 8'h17, 8'hC1, 8'hCB, 8'h11, 8'h17,
        8'h05, 8'h20, 8'hF5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hC9,
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
        8'h3C, 8'h42, 8'hB9, 8'hA5, 8'hB9, 8'hA5, 8'h42, 8'h3C,
        8'h21, 8'h04, 8'h01, 8'h11, 8'hA8, 8'h00, 8'h1A, 8'h13,
        8'hBE, 8'h20, 8'hFE, 8'h23, 8'h7D, 8'hFE, 8'h34, 8'h20,
        8'hF5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
        8'hFB, 8'h86, 8'h20, 8'hFE, 8'h3E, 8'h01, 8'hE0, 8'h50
    };

endpackage

`default_nettype wire

// ===== src/cbad_store.sv =====
// ----------------------------------------------------------------------------
// cbad_store
// Work RAM and high RAM as synchronous memories with a registered read port,
// plus the clearing sweep that zeroes both after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module cbad_store (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cbad_pkg::mem_req_t req,
    output logic [7:0]              rdata,
    output logic                    busy
);
    import cbad_pkg::*;

    logic [7:0] wram [WRAM_DEPTH];
    logic [7:0] hram [HRAM_DEPTH];

    logic               clr_busy_reg;
    logic [WRAM_AW-1:0] clr_cnt_reg;
    logic [7:0]         rdata_reg;

    logic               wram_we;
    logic [WRAM_AW-1:0] wram_wa;
    logic               hram_we;
    logic [HRAM_AW-1:0] hram_wa;
    logic [7:0]         wd;

    // clearing sweep, one entry of each memory per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clr_busy_reg) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == WRAM_AW'(WRAM_DEPTH - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // write port select: sweep or bus write
    always_comb begin
        if (clr_busy_reg) begin
            wram_we = 1'b1;
            wram_wa = clr_cnt_reg;
            hram_we = (clr_cnt_reg < WRAM_AW'(HRAM_DEPTH));
            hram_wa = clr_cnt_reg[HRAM_AW-1:0];
            wd      = '0;
        end else begin
            wram_we = req.wr_en & ~req.hram_sel;
            wram_wa = req.waddr;
            hram_we = req.wr_en & req.hram_sel;
            hram_wa = req.haddr;
            wd      = req.wdata;
        end
    end

    // memory arrays
    always_ff @(posedge aclk) begin
        if (wram_we) begin
            wram[wram_wa] <= wd;
        end
        if (hram_we) begin
            hram[hram_wa] <= wd;
        end
        if (req.rd_en) begin
            rdata_reg <= req.hram_sel ? hram[req.haddr] : wram[req.waddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

`default_nettype wire

// ===== src/cbad_outq.sv =====
// ----------------------------------------------------------------------------
// cbad_outq
// Two-word result queue in front of the master-side stream port.
// ----------------------------------------------------------------------------
`default_nettype none

module cbad_outq (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire cbad_pkg::result_t push_word,
    output logic                   can_push,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output cbad_pkg::result_t      out_word
);
    import cbad_pkg::*;

    result_t    slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign can_push  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_word  = slot_reg[rd_ptr_reg];
    assign pop       = out_valid & out_ready;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // word storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

`default_nettype wire

// ===== src/console_bus_address_decoder.sv =====
// ----------------------------------------------------------------------------
// console_bus_address_decoder
// Memory map decoder: answers boot ROM, work RAM, high RAM and the IF, IE and
// boot-disable registers locally, forwards the rest with a target code, and
// divides clock ticks into processor and DMA steps.
// ----------------------------------------------------------------------------
// path: a result word goes through the stage-one register and the output queue
// throughput: one word per cycle unless the output queue is full, set by the single
//   read port of the ram store (issued at accept, data registered in the cycle after)
// reset: synchronous, active low; afterwards a clearing sweep zeroes work RAM
//   and high RAM, and s_tready stays low until it ends
// ----------------------------------------------------------------------------
`default_nettype none

module console_bus_address_decoder #(
    parameter logic [7:0] DMA_RUN_LENGTH = cbad_pkg::DMA_LENGTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // addr[15:0], data[23:16]
    input  wire logic [3:0]  s_tuser,   // cmd[2:0], from_dma[3]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // rdata[7:0], fwd_addr[23:8], fwd_data[31:24],
                                        // oam_by_dma[32], cpu_step[33], dma_step[34],
                                        // periph_tick[35], halted_now[36],
                                        // int_check_now[37], zero[39:38]
    output logic [3:0]       m_tuser    // target[2:0], fwd_write[3]
);
    import cbad_pkg::*;

    // control registers
    logic [7:0] irq_flags_reg,  irq_flags_next;
    logic [7:0] irq_enable_reg, irq_enable_next;
    logic [7:0] boot_off_reg,   boot_off_next;
    logic       dma_active_reg, dma_active_next;
    logic [7:0] dma_prog_reg,   dma_prog_next;
    logic       halt_reg,       halt_next;
    logic       check_reg,      check_next;
    logic [1:0] phase_reg,      phase_next;

    // pipeline stage holding the decoded word while memory data arrives
    logic    p1_valid_reg;
    logic    p1_use_mem_reg;
    result_t p1_res_reg;

    logic        accept;
    logic        advance;
    logic [2:0]  cmd;
    logic [15:0] a;
    logic [7:0]  d;
    logic        from_dma;

    result_t  res;
    logic     use_mem;
    mem_req_t mreq;
    mem_req_t store_req;
    logic     store_busy;
    logic [7:0] mem_rdata;

    result_t q_in;
    logic    q_can_push;
    result_t q_out;

    logic [7:0] prog_inc;

    assign cmd      = s_tuser[2:0];
    assign from_dma = s_tuser[3];
    assign a        = s_tdata[15:0];
    assign d        = s_tdata[23:16];

    // io register region target
    function automatic target_t io_target(input logic [15:0] ad, input logic is_wr);
        target_t t;
        t = T_IGNORED;
        if (ad == ADDR_JOYPAD) begin
            t = T_JOYPAD;
        end else if (ad >= ADDR_TIMER_LO && ad <= ADDR_TIMER_HI) begin
            t = T_TIMER;
        end else if (ad >= ADDR_VID_LO && ad <= ADDR_VID_HI) begin
            t = (is_wr && ad == ADDR_LINE) ? T_IGNORED : T_VIDREG;
        end
        return t;
    endfunction

    assign prog_inc = dma_prog_reg + 8'd1;

    // decode of the offered word against current state
    always_comb begin
        res             = '0;
        res.target      = T_IGNORED;
        use_mem         = 1'b0;
        mreq            = '0;
        mreq.waddr      = a[WRAM_AW-1:0];    // window bases are multiples of the depth
        mreq.haddr      = HRAM_AW'(a - ADDR_HRAM_LO);
        mreq.wdata      = d;
        irq_flags_next  = irq_flags_reg;
        irq_enable_next = irq_enable_reg;
        boot_off_next   = boot_off_reg;
        dma_active_next = dma_active_reg;
        dma_prog_next   = dma_prog_reg;
        halt_next       = halt_reg;
        check_next      = check_reg;
        phase_next      = phase_reg;

        unique case (cmd)
            CMD_READ: begin
                res.target = T_LOCAL;
                res.rdata  = UNMAPPED_BYTE;
                priority if (a <= ADDR_ROM_LAST) begin
                    if (boot_off_reg == 8'd0 && a < ADDR_BOOT_END) begin
                        res.rdata = BOOT_ROM[a[BOOT_AW-1:0]];
                    end else begin
                        res.target = T_CART;
                    end
                end else if (a <= ADDR_VRAM_LAST) begin
                    res.target = T_VRAM;
                end else if (a <= ADDR_XRAM_LAST) begin
                    res.target = T_CART;
                end else if (a <= ADDR_ECHO_LAST) begin
                    // work ram and its echo
                    use_mem      = 1'b1;
                    mreq.rd_en   = 1'b1;
                end else if (a >= ADDR_OAM_FIRST && a <= ADDR_OAM_LAST) begin
                    res.target = T_OAM;
                end else if (a >= ADDR_IO_FIRST && a <= ADDR_IO_LAST) begin
                    if (a == ADDR_IF) begin
                        res.rdata = irq_flags_reg;
                    end else if (a == ADDR_BOOT_OFF) begin
                        res.rdata = boot_off_reg;
                    end else if (io_target(a, 1'b0) != T_IGNORED) begin
                        res.target = io_target(a, 1'b0);
                    end
                end else if (a >= ADDR_HRAM_LO && a <= ADDR_HRAM_HI) begin
                    use_mem       = 1'b1;
                    mreq.rd_en    = 1'b1;
                    mreq.hram_sel = 1'b1;
                end else if (a == ADDR_IE) begin
                    res.rdata = irq_enable_reg;
                end else begin
                    res.rdata = UNMAPPED_BYTE;
                end
                if (res.target != T_LOCAL) begin
                    res.rdata    = '0;
                    res.fwd_addr = a;
                end
            end
            CMD_WRITE: begin
                if (a >= ADDR_HRAM_LO && a <= ADDR_HRAM_HI) begin
                    // high ram stays writable during dma
                    mreq.wr_en    = 1'b1;
                    mreq.hram_sel = 1'b1;
                    res.target    = T_LOCAL;
                end else if (!dma_active_reg || from_dma) begin
                    priority if (a <= ADDR_ROM_LAST) begin
                        if (!(boot_off_reg == 8'd0 && a < ADDR_BOOT_END)) begin
                            res.target = T_CART;
                        end
                    end else if (a <= ADDR_VRAM_LAST) begin
                        res.target = T_VRAM;
                    end else if (a <= ADDR_XRAM_LAST) begin
                        res.target = T_CART;
                    end else if (a <= ADDR_ECHO_LAST) begin
                        mreq.wr_en = 1'b1;
                        res.target = T_LOCAL;
                    end else if (a >= ADDR_OAM_FIRST && a <= ADDR_OAM_LAST) begin
                        res.target     = T_OAM;
                        res.oam_by_dma = from_dma;
                    end else if (a >= ADDR_IO_FIRST && a <= ADDR_IO_LAST) begin
                        if (a == ADDR_IF) begin
                            halt_next      = 1'b0;
                            check_next     = 1'b1;
                            irq_flags_next = d;
                            res.target     = T_LOCAL;
                        end else if (a == ADDR_BOOT_OFF) begin
                            if (boot_off_reg == 8'd0) begin
                                boot_off_next = d;
                            end
                            res.target = T_LOCAL;
                        end else begin
                            res.target = io_target(a, 1'b1);
                            if (a == ADDR_DMA) begin
                                dma_active_next = 1'b1;
                                dma_prog_next   = 8'd0;
                            end
                        end
                    end else if (a == ADDR_IE) begin
                        halt_next = 1'b0;
                        if (d != irq_enable_reg && d != 8'd0) begin
                            check_next = 1'b1;
                        end
                        irq_enable_next = d;
                        res.target      = T_LOCAL;
                    end else begin
                        res.target = T_IGNORED;
                    end
                end
                if (res.target != T_LOCAL && res.target != T_IGNORED) begin
                    res.fwd_write = 1'b1;
                    res.fwd_addr  = a;
                    res.fwd_data  = d;
                end
            end
            CMD_TICK: begin
                if (!halt_reg && phase_reg == 2'd0) begin
                    res.cpu_step = 1'b1;
                    if (dma_active_reg) begin
                        res.dma_step  = 1'b1;
                        dma_prog_next = prog_inc;
                        if (prog_inc == DMA_RUN_LENGTH) begin
                            dma_active_next = 1'b0;
                        end
                    end
                end
                res.periph_tick = 1'b1;
                phase_next      = phase_reg + 2'd1;
            end
            CMD_HALT: begin
                halt_next = 1'b1;
            end
            CMD_ACK: begin
                check_next = 1'b0;
            end
            default: begin
                // undefined command codes leave everything unchanged
            end
        endcase

        res.halted_now    = halt_next;
        res.int_check_now = check_next;
    end

    // handshake and pipeline advance
    assign advance  = p1_valid_reg & q_can_push;
    assign s_tready = ~store_busy & (~p1_valid_reg | q_can_push);
    assign accept   = s_tvalid & s_tready;

    // gate memory requests with the accept
    always_comb begin
        store_req       = mreq;
        store_req.wr_en = mreq.wr_en & accept;
        store_req.rd_en = mreq.rd_en & accept;
    end

    // control state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            irq_flags_reg  <= '0;
            irq_enable_reg <= '0;
            boot_off_reg   <= '0;
            dma_active_reg <= 1'b0;
            dma_prog_reg   <= '0;
            halt_reg       <= 1'b0;
            check_reg      <= 1'b0;
            phase_reg      <= '0;
        end else begin
            if (accept) begin
                irq_flags_reg  <= irq_flags_next;
                irq_enable_reg <= irq_enable_next;
                dma_active_reg <= dma_active_next;
                dma_prog_reg   <= dma_prog_next;
                halt_reg       <= halt_next;
                check_reg      <= check_next;
                phase_reg      <= phase_next;
            end
            // boot skip reloads the boot-disable register
            if (cfg_wr_en) begin
                boot_off_reg <= {7'd0, cfg_wr_data};
            end else if (accept) begin
                boot_off_reg <= boot_off_next;
            end
        end
    end

    // stage one valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (accept) begin
            p1_valid_reg <= 1'b1;
        end else if (advance) begin
            p1_valid_reg <= 1'b0;
        end
    end

    // stage one payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_res_reg     <= res;
            p1_use_mem_reg <= use_mem;
        end
    end

    cbad_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (store_req),
        .rdata   (mem_rdata),
        .busy    (store_busy)
    );

    // merge memory read data into the word
    always_comb begin
        q_in = p1_res_reg;
        if (p1_use_mem_reg) begin
            q_in.rdata = mem_rdata;
        end
    end

    cbad_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance),
        .push_word (q_in),
        .can_push  (q_can_push),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (q_out)
    );

    // output packing
    assign m_tdata = {2'b00, q_out.int_check_now, q_out.halted_now, q_out.periph_tick,
                      q_out.dma_step, q_out.cpu_step, q_out.oam_by_dma,
                      q_out.fwd_data, q_out.fwd_addr, q_out.rdata};
    assign m_tuser = {q_out.fwd_write, q_out.target};

    // nothing comes out while the rams are being cleared
    a_no_out_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        store_busy |-> !m_tvalid)
        else $error("result word during clearing sweep");

    // dma progress stays below the run length while active
    a_dma_prog_range: assert property (@(posedge aclk) disable iff (!aresetn)
        dma_active_reg |-> (dma_prog_reg < DMA_RUN_LENGTH))
        else $error("dma progress beyond run length");

    // a dma step only comes with a processor step
    a_dma_with_cpu: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[34]) |-> m_tdata[33])
        else $error("dma step without cpu step");

    // a memory read is always carried by a stage that is filled next cycle
    a_read_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        store_req.rd_en |=> (p1_valid_reg && p1_use_mem_reg))
        else $error("memory read without pipeline word");

endmodule

`default_nettype wire
